@@ src/ats_pkg.sv @@
// shared types and constants for the asymmetric tanh saturator
// no dependencies; used by every module of the block
`default_nettype none

package ats_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int CHANNELS_DEF     = 2;
  localparam int TANH_ENTRIES_DEF = 256;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ASYMMETRY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_COEFF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_AMOUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd4;

  localparam logic [15:0]        RST_INPUT_GAIN  = 16'd8173;
  localparam logic signed [15:0] RST_ASYMMETRY   = 16'sd3277;
  localparam logic [14:0]        RST_TONE_COEFF  = 15'd23829;
  localparam logic [15:0]        RST_MIX_AMOUNT  = 16'd32768;
  localparam logic [14:0]        RST_OUTPUT_GAIN = 15'd2900;

  localparam logic [15:0] MIX_FULL = 16'd32768;

  // tanh table entries, Q0.15
  localparam int TANH_W = 15;

  // shared multiplier
  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;

  typedef struct packed {
    logic [0:0]                    channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } in_word_t;

  typedef struct packed {
    logic [0:0]                    channel_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        input_gain;
    logic signed [15:0] asymmetry;
    logic [14:0]        tone_coeff;
    logic [15:0]        mix_amount;
    logic [14:0]        output_gain;
  } cfg_t;

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

@@ src/ats_mul.sv @@
// shared signed multiplier with registered product
// depends on ats_pkg
`default_nettype none

module ats_mul (
  input  wire logic                            clk,
  input  wire ats_pkg::mul_req_t               req,
  output logic signed [ats_pkg::PROD_W-1:0]    prod
);
  import ats_pkg::*;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= PROD_W'(req.a) * PROD_W'(req.b);
    end
  end

endmodule

`default_nettype wire

@@ src/ats_tanh_rom.sv @@
// tanh table over [0,8], built at elaboration with integer arithmetic
// registered read port; depends on ats_pkg
`default_nettype none

module ats_tanh_rom #(
  parameter int TANH_TABLE_ENTRIES = ats_pkg::TANH_ENTRIES_DEF,
  localparam int IDX_W = $clog2(TANH_TABLE_ENTRIES + 1)
) (
  input  wire logic                         clk,
  input  wire logic [IDX_W-1:0]             addr,
  output logic [ats_pkg::TANH_W-1:0]        q
);
  import ats_pkg::*;

  localparam longint ONE_Q30    = longint'(1) <<< 30;
  localparam longint EXP_M1_Q30 = 395007542;
  localparam longint TANH_MAX   = 32767;

  // long division, nonnegative operands
  function automatic longint div_pos(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & longint'(1));
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | longint'(1);
      end
    end
    return quo;
  endfunction

  function automatic logic [TANH_W-1:0] tanh_point(input int pt);
    longint k;
    longint r;
    longint f;
    longint pk;
    longint term;
    longint ef;
    longint e;
    longint t;
    k = (16 * longint'(pt)) / TANH_TABLE_ENTRIES;
    r = (16 * longint'(pt)) % TANH_TABLE_ENTRIES;
    f = (r <<< 30) / TANH_TABLE_ENTRIES;
    pk = ONE_Q30;
    term = ONE_Q30;
    ef = ONE_Q30;
    // e^-k by repeated products of e^-1
    for (int n = 0; n < k; n++) begin
      pk = (pk * EXP_M1_Q30 + (ONE_Q30 >>> 1)) >>> 30;
    end
    // e^-f by series
    for (int n = 1; n <= 24; n++) begin
      term = div_pos((term * f) >>> 30, longint'(n));
      ef = n[0] ? ef - term : ef + term;
    end
    e = (pk * ef + (ONE_Q30 >>> 1)) >>> 30;
    t = div_pos(((ONE_Q30 - e) <<< 15) + ((ONE_Q30 + e) >>> 1), ONE_Q30 + e);
    if (t > TANH_MAX) t = TANH_MAX;
    if (t < 0) t = 0;
    return t[TANH_W-1:0];
  endfunction

  logic [TANH_W-1:0] rom [0:TANH_TABLE_ENTRIES];

  for (genvar g = 0; g <= TANH_TABLE_ENTRIES; g++) begin : g_pt
    localparam logic [TANH_W-1:0] PT = tanh_point(g);
    assign rom[g] = PT;
  end

  always_ff @(posedge clk) begin
    q <= rom[addr];
  end

endmodule

`default_nettype wire

@@ src/ats_seq.sv @@
// sequencer and datapath registers: drive, skew, table lookup, tone filter, output gain, mix
// drives the shared multiplier and the tanh table; depends on ats_pkg
`default_nettype none

module ats_seq #(
  parameter int CHANNELS           = ats_pkg::CHANNELS_DEF,
  parameter int TANH_TABLE_ENTRIES = ats_pkg::TANH_ENTRIES_DEF,
  localparam int IDX_W = $clog2(TANH_TABLE_ENTRIES + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ats_pkg::cfg_t                  cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire ats_pkg::in_word_t              in_data,
  output logic                                done_valid,
  input  wire logic                           done_ready,
  output ats_pkg::out_word_t                  done_word,
  output ats_pkg::mul_req_t                   mul_req,
  input  wire logic signed [ats_pkg::PROD_W-1:0] prod,
  output logic [IDX_W-1:0]                    rom_addr,
  input  wire logic [ats_pkg::TANH_W-1:0]     rom_q
);
  import ats_pkg::*;

  localparam int S       = SAMPLE_BITS;
  localparam int F       = S - 1;
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DRV_SH  = F - 4;
  localparam int DRV_W   = S + 17 - DRV_SH;
  localparam int SQ_W    = 2 * DRV_W - 2;
  localparam int SQ_LO_W = SQ_W / 2;
  localparam int SQ_HI_W = SQ_W - SQ_LO_W;
  localparam int ASYM_SH = 31;
  localparam int ACC_W   = 16 + SQ_W + 1;
  localparam int SKEW_W  = ACC_W - ASYM_SH + 1;
  localparam int SAT_MAG = 8 << 16;
  localparam int MAG_W   = 20;
  localparam int POS_SH  = 19;
  localparam int Y_W     = TANH_W + 2;
  localparam int ST_W    = 16;
  localparam int TD_W    = Y_W + 1;
  localparam int TONE_SH = 15;
  localparam int WET_SH  = 12;
  localparam int WET_UP  = (F >= 15) ? F - 15 : 0;
  localparam int WET_DN  = (F < 15) ? 15 - F : 0;
  localparam int WET_HALF = (WET_DN > 0) ? (1 << (WET_DN - 1)) : 0;
  localparam int WET_W   = 20 + WET_UP;
  localparam int WD_W    = ((WET_W > S) ? WET_W : S) + 1;
  localparam int MIX_SH  = 15;

  localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(longint'(1) <<< (ASYM_SH - 1));
  localparam logic signed [PROD_W-1:0] RES_MAX  = PROD_W'((longint'(1) <<< F) - 1);
  localparam logic signed [PROD_W-1:0] RES_MIN  = PROD_W'(-(longint'(1) <<< F));
  localparam logic [IDX_W-1:0]         IDX_LAST = IDX_W'(TANH_TABLE_ENTRIES);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_M_DRV  = 5'd1;
  localparam logic [4:0] ST_P_DRV  = 5'd2;
  localparam logic [4:0] ST_M_SQ   = 5'd3;
  localparam logic [4:0] ST_M_ALO  = 5'd4;
  localparam logic [4:0] ST_M_AHI  = 5'd5;
  localparam logic [4:0] ST_P_ACC  = 5'd6;
  localparam logic [4:0] ST_P_SKEW = 5'd7;
  localparam logic [4:0] ST_P_MAG  = 5'd8;
  localparam logic [4:0] ST_M_POS  = 5'd9;
  localparam logic [4:0] ST_RD_A   = 5'd10;
  localparam logic [4:0] ST_RD_B   = 5'd11;
  localparam logic [4:0] ST_M_INT  = 5'd12;
  localparam logic [4:0] ST_P_INT  = 5'd13;
  localparam logic [4:0] ST_P_SOFT = 5'd14;
  localparam logic [4:0] ST_M_TONE = 5'd15;
  localparam logic [4:0] ST_P_TONE = 5'd16;
  localparam logic [4:0] ST_M_WET  = 5'd17;
  localparam logic [4:0] ST_P_WET  = 5'd18;
  localparam logic [4:0] ST_P_WD   = 5'd19;
  localparam logic [4:0] ST_M_MIX  = 5'd20;
  localparam logic [4:0] ST_DONE   = 5'd21;

  // round to nearest, ties toward plus infinity
  function automatic logic signed [PROD_W-1:0] rsh_rnd(
    input logic signed [PROD_W-1:0] v,
    input int                       n
  );
    logic signed [PROD_W-1:0] half;
    half = '0;
    half[n-1] = 1'b1;
    return (v + half) >>> n;
  endfunction

  logic [4:0]               state;
  logic [4:0]               state_next;
  logic signed [ST_W-1:0]   tone_state [CHANNELS];

  logic [0:0]               chan;
  logic [CH_W-1:0]          ch_idx;
  logic [CH_W-1:0]          ch_sel;
  logic signed [S-1:0]      dry;
  logic signed [DRV_W-1:0]  driven;
  logic [SQ_HI_W-1:0]       sq_hi;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SKEW_W-1:0] skew;
  logic signed [SKEW_W-1:0] skew_abs;
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [TANH_W-1:0]        a_pt;
  logic signed [Y_W-1:0]    y;
  logic signed [Y_W-1:0]    shaped;
  logic signed [TD_W-1:0]   td;
  logic signed [ST_W-1:0]   st_next;
  logic signed [ST_W-1:0]   stn;
  logic signed [PROD_W-1:0] wet_raw;
  logic signed [PROD_W-1:0] wet_scaled;
  logic signed [WET_W-1:0]  wetf;
  logic signed [WD_W-1:0]   wd;
  logic signed [PROD_W-1:0] res_full;
  logic signed [PROD_W-1:0] res_sat;
  logic [15:0]              mix_c;
  logic [IDX_W-1:0]         idx_p;

  assign in_ready   = (state == ST_IDLE);
  assign done_valid = (state == ST_DONE);

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = in_valid ? ST_M_DRV : ST_IDLE;
      ST_DONE: state_next = done_ready ? ST_IDLE : ST_DONE;
      default: state_next = state + 5'd1;
    endcase
  end

  always_comb begin
    if (int'(in_data.channel) >= CHANNELS) begin
      ch_sel = CH_W'(CHANNELS - 1);
    end else begin
      ch_sel = CH_W'(in_data.channel);
    end
  end

  always_comb begin
    skew_abs   = skew[SKEW_W-1] ? -skew : skew;
    shaped     = neg ? -y : y;
    st_next    = tone_state[ch_idx] + ST_W'(rsh_rnd(prod, TONE_SH));
    wet_raw    = rsh_rnd(prod, WET_SH);
    wet_scaled = ((wet_raw + PROD_W'(WET_HALF)) >>> WET_DN) <<< WET_UP;
    mix_c      = (cfg.mix_amount > MIX_FULL) ? MIX_FULL : cfg.mix_amount;
    res_full   = PROD_W'(dry) + rsh_rnd(prod, MIX_SH);
    if (res_full > RES_MAX) begin
      res_sat = RES_MAX;
    end else if (res_full < RES_MIN) begin
      res_sat = RES_MIN;
    end else begin
      res_sat = res_full;
    end
  end

  // table position sits in the product register from the position multiply on
  assign idx_p    = prod[POS_SH +: IDX_W];
  assign rom_addr = (state == ST_RD_B && idx_p != IDX_LAST) ? idx_p + IDX_W'(1) : idx_p;

  always_comb begin
    done_word.channel_out = chan;
    done_word.sample_out  = res_sat[S-1:0];
  end

  always_comb begin
    mul_req = '0;
    unique case (state)
      ST_M_DRV: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(dry);
        mul_req.b  = $signed(MUL_W'(cfg.input_gain));
      end
      ST_M_SQ: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(driven);
        mul_req.b  = MUL_W'(driven);
      end
      ST_M_ALO: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(cfg.asymmetry);
        mul_req.b  = $signed(MUL_W'(prod[SQ_LO_W-1:0]));
      end
      ST_M_AHI: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(cfg.asymmetry);
        mul_req.b  = $signed(MUL_W'(sq_hi));
      end
      ST_M_POS: begin
        mul_req.en = 1'b1;
        mul_req.a  = $signed(MUL_W'(mag));
        mul_req.b  = MUL_W'(TANH_TABLE_ENTRIES);
      end
      ST_M_INT: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'($signed({1'b0, rom_q}) - $signed({1'b0, a_pt}));
        mul_req.b  = $signed(MUL_W'(prod[POS_SH-1:0]));
      end
      ST_M_TONE: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(td);
        mul_req.b  = $signed(MUL_W'(cfg.tone_coeff));
      end
      ST_M_WET: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(stn);
        mul_req.b  = $signed(MUL_W'(cfg.output_gain));
      end
      ST_M_MIX: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(wd);
        mul_req.b  = $signed(MUL_W'(mix_c));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int c = 0; c < CHANNELS; c++) begin
        tone_state[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_P_TONE) begin
        tone_state[ch_idx] <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        chan   <= in_data.channel;
        ch_idx <= ch_sel;
        dry    <= in_data.sample_in;
      end
      ST_P_DRV:  driven <= DRV_W'(rsh_rnd(prod, DRV_SH));
      ST_M_ALO:  sq_hi <= prod[SQ_LO_W +: SQ_HI_W];
      ST_M_AHI:  acc <= ACC_W'(prod) + ACC_HALF;
      ST_P_ACC:  acc <= acc + (ACC_W'(prod) <<< SQ_LO_W);
      ST_P_SKEW: skew <= SKEW_W'(driven) + SKEW_W'(acc >>> ASYM_SH);
      ST_P_MAG: begin
        neg <= skew[SKEW_W-1];
        if (skew_abs > SKEW_W'(SAT_MAG)) begin
          mag <= MAG_W'(SAT_MAG);
        end else begin
          mag <= MAG_W'(skew_abs);
        end
      end
      ST_RD_B:   a_pt <= rom_q;
      ST_P_INT:  y <= Y_W'($signed({1'b0, a_pt})) + Y_W'(rsh_rnd(prod, POS_SH));
      ST_P_SOFT: td <= TD_W'(shaped) - TD_W'(tone_state[ch_idx]);
      ST_P_TONE: stn <= st_next;
      ST_P_WET:  wetf <= WET_W'(wet_scaled);
      ST_P_WD:   wd <= WD_W'(wetf) - WD_W'(dry);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ src/asymmetric_tanh_saturator.sv @@
// asymmetric tanh saturator: top level with config registers and output register
// the output word is registered from the sequencer's done state
// each word takes nine passes through the shared multiplier
// plus two reads of the tanh table, one item in flight at a time
// reset (rst, synchronous): idle, output empty, filter state zero, registers at defaults
// depends on ats_pkg, ats_seq, ats_mul, ats_tanh_rom
`default_nettype none

module asymmetric_tanh_saturator #(
  parameter int CHANNELS           = ats_pkg::CHANNELS_DEF,
  parameter int TANH_TABLE_ENTRIES = ats_pkg::TANH_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ats_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ats_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire ats_pkg::in_word_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output ats_pkg::out_word_t                 out_data
);
  import ats_pkg::*;

  localparam int IDX_W = $clog2(TANH_TABLE_ENTRIES + 1);

  cfg_t                     cfg;
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;
  logic [IDX_W-1:0]         rom_addr;
  logic [TANH_W-1:0]        rom_q;
  logic                     done_valid;
  logic                     done_ready;
  out_word_t                done_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_gain  <= RST_INPUT_GAIN;
      cfg.asymmetry   <= RST_ASYMMETRY;
      cfg.tone_coeff  <= RST_TONE_COEFF;
      cfg.mix_amount  <= RST_MIX_AMOUNT;
      cfg.output_gain <= RST_OUTPUT_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUT_GAIN:  cfg.input_gain  <= cfg_data;
        REG_ASYMMETRY:   cfg.asymmetry   <= $signed(cfg_data);
        REG_TONE_COEFF:  cfg.tone_coeff  <= cfg_data[14:0];
        REG_MIX_AMOUNT:  cfg.mix_amount  <= cfg_data;
        REG_OUTPUT_GAIN: cfg.output_gain <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // output register frees the sequencer while a word waits downstream
  assign done_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      out_data <= done_word;
    end
  end

  ats_seq #(
    .CHANNELS           (CHANNELS),
    .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done_word  (done_word),
    .mul_req    (mul_req),
    .prod       (prod),
    .rom_addr   (rom_addr),
    .rom_q      (rom_q)
  );

  ats_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  ats_tanh_rom #(
    .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

endmodule

`default_nettype wire

@@ src/ats_checker.sv @@
// port-level checks for the asymmetric tanh saturator
// bound to the top level below; depends on ats_pkg
`default_nettype none

module ats_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire ats_pkg::out_word_t out_data
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accept");

  // no result can appear the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("output word appeared too early");

  // reset leaves the block idle and empty
  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind asymmetric_tanh_saturator ats_checker u_ats_checker (.*);

`default_nettype wire

@@ test/testbench.sv @@
// self-checking testbench for asymmetric_tanh_saturator: directed and random words
// predicts every output word with its own fixed-point model of the shaper and filter
// depends on ats_pkg and asymmetric_tanh_saturator
`timescale 1ns / 1ps

module testbench;
  import ats_pkg::*;

  localparam int     CYCLE_LIMIT = 500000;
  localparam int     SETTLE      = 30;
  localparam int     LUT_N       = TANH_ENTRIES_DEF;
  localparam longint Q30_ONE     = longint'(1) <<< 30;
  localparam longint EXP_M1_Q30  = 395007542;
  localparam longint SAT_LIMIT   = longint'(8) <<< 16;
  localparam longint MIX_MAX     = 32768;
  localparam longint SMP_MAX     = 32767;
  localparam longint SMP_MIN     = -32768;
  localparam int     RAND_PHASES = 8;
  localparam int     PHASE_WORDS = 110;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;

  cfg_t               settings;
  logic signed [15:0] tone_state [CHANNELS_DEF];
  longint             tanh_lut [LUT_N + 1];
  out_word_t          pending_out [$];
  out_word_t          want_word;
  int                 fail_count = 0;
  int                 cycle_count = 0;
  int                 stall_left = 0;
  bit                 idle_on = 1'b1;

  asymmetric_tanh_saturator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) begin
        out_ready <= 1'b1;
      end
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected word, actual channel %0d sample %0d", $time,
                 out_data.channel_out, $signed(out_data.sample_out));
        fail_count++;
      end else begin
        want_word = pending_out.pop_front();
        if (want_word.channel_out !== out_data.channel_out) begin
          $display("%0t: channel_out expected %0d actual %0d", $time,
                   want_word.channel_out, out_data.channel_out);
          fail_count++;
        end
        if (want_word.sample_out !== out_data.sample_out) begin
          $display("%0t: sample_out expected %0d actual %0d", $time,
                   $signed(want_word.sample_out), $signed(out_data.sample_out));
          fail_count++;
        end
      end
    end
  end

  // round to nearest, ties toward plus infinity
  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic void build_tanh_lut();
    longint k, r, f, pk, term, ef, e, t;
    int     i, n;
    for (i = 0; i <= LUT_N; i++) begin
      k = (longint'(16) * i) / LUT_N;
      r = (longint'(16) * i) % LUT_N;
      f = (r <<< 30) / LUT_N;
      pk = Q30_ONE;
      term = Q30_ONE;
      ef = Q30_ONE;
      for (n = 0; n < k; n++) begin
        pk = (pk * EXP_M1_Q30 + (Q30_ONE >>> 1)) >>> 30;
      end
      for (n = 1; n <= 24; n++) begin
        term = ((term * f) >>> 30) / n;
        ef = (n % 2 == 1) ? ef - term : ef + term;
      end
      e = (pk * ef + (Q30_ONE >>> 1)) >>> 30;
      t = (((Q30_ONE - e) <<< 15) + ((Q30_ONE + e) >>> 1)) / (Q30_ONE + e);
      if (t > SMP_MAX) t = SMP_MAX;
      if (t < 0) t = 0;
      tanh_lut[i] = t;
    end
  endfunction

  // drive, skew, tanh, lowpass, output gain, dry/wet blend
  function automatic out_word_t saturate_sample(in_word_t w);
    longint    dry, driven, skew, mag, pos, idx, frac, shaped, st, wet, mix, res;
    out_word_t result;
    dry = longint'($signed(w.sample_in));
    driven = round_shift(dry * longint'(settings.input_gain), 11);
    skew = driven + round_shift(longint'($signed(settings.asymmetry)) * (driven * driven), 31);
    if (skew > SAT_LIMIT) skew = SAT_LIMIT;
    if (skew < -SAT_LIMIT) skew = -SAT_LIMIT;
    mag = (skew < 0) ? -skew : skew;
    pos = mag * LUT_N;
    idx = pos >>> 19;
    frac = pos & ((longint'(1) <<< 19) - 1);
    if (idx >= LUT_N) begin
      shaped = tanh_lut[LUT_N];
    end else begin
      shaped = tanh_lut[idx] + round_shift((tanh_lut[idx + 1] - tanh_lut[idx]) * frac, 19);
    end
    if (skew < 0) shaped = -shaped;
    st = longint'(tone_state[w.channel]);
    st = st + round_shift(longint'(settings.tone_coeff) * (shaped - st), 15);
    tone_state[w.channel] = st[15:0];
    wet = round_shift(st * longint'(settings.output_gain), 12);
    mix = (longint'(settings.mix_amount) > MIX_MAX) ? MIX_MAX : longint'(settings.mix_amount);
    res = dry + round_shift(mix * (wet - dry), 15);
    if (res > SMP_MAX) res = SMP_MAX;
    if (res < SMP_MIN) res = SMP_MIN;
    result.channel_out = w.channel;
    result.sample_out = res[15:0];
    return result;
  endfunction

  task automatic send_word(in_word_t w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_out = {pending_out, saturate_sample(w)};
  endtask

  task automatic send_sample(logic ch, logic signed [15:0] s);
    in_word_t w;
    w.channel = ch;
    w.sample_in = s;
    send_word(w);
  endtask

  // block must be empty before any register write
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_INPUT_GAIN:  settings.input_gain = data;
      REG_ASYMMETRY:   settings.asymmetry = data;
      REG_TONE_COEFF:  settings.tone_coeff = data[14:0];
      REG_MIX_AMOUNT:  settings.mix_amount = data;
      REG_OUTPUT_GAIN: settings.output_gain = data[14:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(cfg_t c);
    wait_idle();
    write_reg(REG_INPUT_GAIN, c.input_gain);
    write_reg(REG_ASYMMETRY, c.asymmetry);
    write_reg(REG_TONE_COEFF, CFG_W'(c.tone_coeff));
    write_reg(REG_MIX_AMOUNT, c.mix_amount);
    write_reg(REG_OUTPUT_GAIN, CFG_W'(c.output_gain));
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    case ($urandom_range(0, 3))
      0:       c.input_gain = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      1:       c.input_gain = 16'($urandom());
      default: c.input_gain = 16'($urandom_range(0, 16383));
    endcase
    case ($urandom_range(0, 5))
      0:       c.asymmetry = ($urandom_range(0, 1) == 1) ? 16'sd16384 : -16'sd16384;
      1:       c.asymmetry = 16'($urandom());
      default: c.asymmetry = 16'($urandom_range(0, 32768) - 16384);
    endcase
    case ($urandom_range(0, 4))
      0:       c.tone_coeff = ($urandom_range(0, 1) == 1) ? 15'h7FFF : 15'h0000;
      default: c.tone_coeff = 15'($urandom());
    endcase
    case ($urandom_range(0, 5))
      0:       c.mix_amount = ($urandom_range(0, 1) == 1) ? MIX_FULL : 16'h0000;
      1:       c.mix_amount = 16'($urandom());
      default: c.mix_amount = 16'($urandom_range(0, 32768));
    endcase
    case ($urandom_range(0, 4))
      0:       c.output_gain = ($urandom_range(0, 1) == 1) ? 15'h7FFF : 15'h0000;
      default: c.output_gain = 15'($urandom());
    endcase
    return c;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.channel = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       w.sample_in = 16'sh7FFF;
          1:       w.sample_in = 16'sh8000;
          2:       w.sample_in = 16'sh0000;
          default: w.sample_in = 16'shFFFF;
        endcase
      end
      1:       w.sample_in = 16'($urandom_range(0, 512) - 256);
      default: w.sample_in = 16'($urandom());
    endcase
    return w;
  endfunction

  task automatic test_default_settings();
    send_sample(1'b0, 16'sd0);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b1, -16'sd32768);
    send_sample(1'b1, 16'sd1);
    send_sample(1'b0, -16'sd1);
    send_sample(1'b1, 16'sd16384);
  endtask

  // skew driven past the table end in both directions
  task automatic test_saturation();
    cfg_t c;
    c = settings;
    c.input_gain = 16'hFFFF;
    c.asymmetry = 16'sd16384;
    load_settings(c);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b1, -16'sd32768);
    send_sample(1'b1, 16'sd12000);
    c.asymmetry = -16'sd16384;
    load_settings(c);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b1, -16'sd32768);
    c.asymmetry = 16'sh7FFF;
    load_settings(c);
    send_sample(1'b0, 16'sd20000);
    c.asymmetry = 16'sh8000;
    load_settings(c);
    send_sample(1'b1, -16'sd20000);
  endtask

  // output clamp, mix above full scale, fully dry with frozen filter
  task automatic test_mix_and_gain();
    cfg_t c;
    c = settings;
    c.input_gain = 16'd8192;
    c.asymmetry = 16'sd0;
    c.tone_coeff = 15'h7FFF;
    c.output_gain = 15'h7FFF;
    c.mix_amount = MIX_FULL;
    load_settings(c);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b1, -16'sd32768);
    c.mix_amount = 16'hFFFF;
    load_settings(c);
    send_sample(1'b0, -16'sd32768);
    send_sample(1'b1, 16'sd32767);
    c.input_gain = 16'h0000;
    c.tone_coeff = 15'h0000;
    c.output_gain = 15'h0000;
    c.mix_amount = 16'h0000;
    load_settings(c);
    send_sample(1'b0, 16'sd12345);
    send_sample(1'b1, -16'sd32768);
  endtask

  // writes to indexes past the last register change nothing
  task automatic test_unused_index();
    logic [CFG_IDX_W-1:0] idx;
    wait_idle();
    for (idx = REG_OUTPUT_GAIN + 3'd1; idx != 0; idx++) begin
      write_reg(idx, CFG_W'($urandom()));
    end
    cfg_we <= 1'b0;
    send_sample(1'b0, 16'sd3000);
    send_sample(1'b1, -16'sd3000);
  endtask

  task automatic test_random_traffic();
    int phase, i;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      load_settings(random_settings());
      idle_on = (phase != RAND_PHASES - 1);
      for (i = 0; i < PHASE_WORDS; i++) begin
        send_word(random_word());
      end
    end
  endtask

  initial begin
    build_tanh_lut();
    settings.input_gain = RST_INPUT_GAIN;
    settings.asymmetry = RST_ASYMMETRY;
    settings.tone_coeff = RST_TONE_COEFF;
    settings.mix_amount = RST_MIX_AMOUNT;
    settings.output_gain = RST_OUTPUT_GAIN;
    foreach (tone_state[i]) tone_state[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_settings();
    test_saturation();
    test_mix_and_gain();
    test_unused_index();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ats_pkg.sv
src/ats_mul.sv
src/ats_tanh_rom.sv
src/ats_seq.sv
src/asymmetric_tanh_saturator.sv
src/ats_checker.sv
test/testbench.sv
